/* src/bsaf_pkg.sv */
// ----------------------------------------------------------------------------
// bsaf_pkg - shared types for the barrel shifter ALU
// Transfer payloads, queue entry layout, opcode and shift kind codes.
// ----------------------------------------------------------------------------
package bsaf_pkg;

  typedef enum logic [3:0] {
    ALU_AND = 4'd0,
    ALU_EOR = 4'd1,
    ALU_SUB = 4'd2,
    ALU_RSB = 4'd3,
    ALU_ADD = 4'd4,
    ALU_ADC = 4'd5,
    ALU_SBC = 4'd6,
    ALU_RSC = 4'd7,
    ALU_TST = 4'd8,
    ALU_TEQ = 4'd9,
    ALU_CMP = 4'd10,
    ALU_CMN = 4'd11,
    ALU_ORR = 4'd12,
    ALU_MOV = 4'd13,
    ALU_BIC = 4'd14,
    ALU_MVN = 4'd15
  } alu_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  localparam logic [1:0] TestGroup = 2'b10;
  localparam logic [3:0] PcIndex   = 4'd15;

  typedef struct packed {
    logic [3:0]  func;
    logic        set_flags;
    logic        use_immediate;
    logic [7:0]  imm_byte;
    logic [3:0]  rotate_amount;
    logic [2:0]  shift_kind;
    logic [4:0]  shift_amount;
    logic [3:0]  dest_index;
    logic [31:0] first_operand;
    logic [31:0] shift_source;
    logic [7:0]  shift_count_byte;
    logic [3:0]  flags_in;
  } in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_dest;
    logic [3:0]  dest_out;
    logic [3:0]  nzcv_out;
    logic        flags_write;
  } out_t;

  // decoded operation handed from front to back
  typedef struct packed {
    alu_e        func;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic        shift_carry;
    logic [3:0]  flags_in;
    logic [3:0]  dest;
    logic        write_dest;
    logic        flags_write;
  } op_t;

endpackage

/* src/bsaf_front.sv */
// ----------------------------------------------------------------------------
// bsaf_front - operand shifter and writeback classification
// Builds the second operand and shifter carry, decides register/flag writes.
// ----------------------------------------------------------------------------
module bsaf_front (
  input  bsaf_pkg::in_t item_i,
  input  logic          core_variant_i,
  output bsaf_pkg::op_t op_o
);

  logic [31:0]        src;
  logic               cin;
  logic [7:0]         amt;
  logic [4:0]         amt_lo;
  logic               amt_big;
  logic               amt_eq32;
  logic               pass;
  logic               rrx;
  logic [1:0]         kind;
  logic [32:0]        lsl_w;
  logic [32:0]        lsr_w;
  logic signed [32:0] asr_w;
  logic [63:0]        ror_w;
  logic [63:0]        imm_w;
  logic [31:0]        sh_val;
  logic               sh_c;
  logic [31:0]        b_val;
  logic               b_c;
  logic               is_test;

  assign src     = item_i.shift_source;
  assign cin     = item_i.flags_in[1];
  assign kind    = item_i.shift_kind[2:1];

  always_comb begin
    if (item_i.shift_kind[0]) begin
      amt  = item_i.shift_count_byte;
      pass = (item_i.shift_count_byte == 8'd0);
      rrx  = 1'b0;
    end else begin
      amt  = (item_i.shift_amount != 5'd0) ? {3'd0, item_i.shift_amount} : 8'd32;
      pass = (item_i.shift_amount == 5'd0) && (kind == bsaf_pkg::SH_LSL);
      rrx  = (item_i.shift_amount == 5'd0) && (kind == bsaf_pkg::SH_ROR);
    end
  end

  assign amt_lo   = amt[4:0];
  assign amt_big  = |amt[7:5];
  assign amt_eq32 = (amt == 8'd32);
  assign lsl_w    = {1'b0, src} << amt_lo;
  assign lsr_w    = {src, 1'b0} >> amt_lo;
  assign asr_w    = $signed({src, 1'b0}) >>> amt_lo;
  assign ror_w    = {src, src} >> amt_lo;
  assign imm_w    = {24'd0, item_i.imm_byte, 24'd0, item_i.imm_byte}
                    >> {item_i.rotate_amount, 1'b0};

  always_comb begin
    unique case (bsaf_pkg::shift_e'(kind))
      bsaf_pkg::SH_LSL: begin
        sh_val = amt_big ? 32'd0 : lsl_w[31:0];
        sh_c   = amt_big ? (amt_eq32 & src[0]) : lsl_w[32];
      end
      bsaf_pkg::SH_LSR: begin
        sh_val = amt_big ? 32'd0 : lsr_w[32:1];
        sh_c   = amt_big ? (amt_eq32 & src[31]) : lsr_w[0];
      end
      bsaf_pkg::SH_ASR: begin
        sh_val = amt_big ? {32{src[31]}} : asr_w[32:1];
        sh_c   = amt_big ? src[31] : asr_w[0];
      end
      default: begin
        sh_val = ror_w[31:0];
        sh_c   = ror_w[31];
      end
    endcase
  end

  always_comb begin
    priority if (item_i.use_immediate) begin
      if (item_i.rotate_amount == 4'd0) begin
        b_val = {24'd0, item_i.imm_byte};
        b_c   = cin;
      end else begin
        b_val = imm_w[31:0];
        b_c   = imm_w[31];
      end
    end else if (pass) begin
      b_val = src;
      b_c   = cin;
    end else if (rrx) begin
      b_val = {cin, src[31:1]};
      b_c   = src[0];
    end else begin
      b_val = sh_val;
      b_c   = sh_c;
    end
  end

  assign is_test = (item_i.func[3:2] == bsaf_pkg::TestGroup);

  always_comb begin
    op_o.func        = bsaf_pkg::alu_e'(item_i.func);
    op_o.op_a        = item_i.first_operand;
    op_o.op_b        = b_val;
    op_o.shift_carry = b_c;
    op_o.flags_in    = item_i.flags_in;
    op_o.dest        = item_i.dest_index;
    if (is_test) begin
      op_o.write_dest  = (item_i.dest_index == bsaf_pkg::PcIndex) && core_variant_i;
      op_o.flags_write = !op_o.write_dest;
    end else begin
      op_o.write_dest  = 1'b1;
      op_o.flags_write = item_i.set_flags;
    end
  end

endmodule

/* src/bsaf_queue.sv */
// ----------------------------------------------------------------------------
// bsaf_queue - short register queue between front and back
// Holds decoded operations so either side can stall independently.
// ----------------------------------------------------------------------------
module bsaf_queue #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsaf_pkg::op_t data_i,
  input  logic          pop_i,
  output bsaf_pkg::op_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bsaf_pkg::op_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count out of range");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

/* src/bsaf_back.sv */
// ----------------------------------------------------------------------------
// bsaf_back - ALU, flag generation and output register
// Executes one decoded operation per transfer and holds the result.
// ----------------------------------------------------------------------------
module bsaf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  bsaf_pkg::op_t  op_i,
  output logic           op_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bsaf_pkg::out_t out_data_o
);

  logic [31:0]    x, y, res, logic_res;
  logic           add_cin;
  logic           is_arith;
  logic [32:0]    sum;
  logic           c_new, v_new;
  logic           valid_q;
  bsaf_pkg::out_t out_q, out_d;

  always_comb begin
    x         = op_i.op_a;
    y         = op_i.op_b;
    add_cin   = 1'b0;
    is_arith  = 1'b1;
    logic_res = '0;
    unique case (op_i.func)
      bsaf_pkg::ALU_AND, bsaf_pkg::ALU_TST: begin
        is_arith  = 1'b0;
        logic_res = op_i.op_a & op_i.op_b;
      end
      bsaf_pkg::ALU_EOR, bsaf_pkg::ALU_TEQ: begin
        is_arith  = 1'b0;
        logic_res = op_i.op_a ^ op_i.op_b;
      end
      bsaf_pkg::ALU_SUB, bsaf_pkg::ALU_CMP: begin
        y       = ~op_i.op_b;
        add_cin = 1'b1;
      end
      bsaf_pkg::ALU_RSB: begin
        x       = op_i.op_b;
        y       = ~op_i.op_a;
        add_cin = 1'b1;
      end
      bsaf_pkg::ALU_ADD, bsaf_pkg::ALU_CMN: begin
        add_cin = 1'b0;
      end
      bsaf_pkg::ALU_ADC: begin
        add_cin = op_i.flags_in[1];
      end
      bsaf_pkg::ALU_SBC: begin
        y       = ~op_i.op_b;
        add_cin = op_i.flags_in[1];
      end
      bsaf_pkg::ALU_RSC: begin
        x       = op_i.op_b;
        y       = ~op_i.op_a;
        add_cin = op_i.flags_in[1];
      end
      bsaf_pkg::ALU_ORR: begin
        is_arith  = 1'b0;
        logic_res = op_i.op_a | op_i.op_b;
      end
      bsaf_pkg::ALU_MOV: begin
        is_arith  = 1'b0;
        logic_res = op_i.op_b;
      end
      bsaf_pkg::ALU_BIC: begin
        is_arith  = 1'b0;
        logic_res = op_i.op_a & ~op_i.op_b;
      end
      default: begin
        is_arith  = 1'b0;
        logic_res = ~op_i.op_b;
      end
    endcase
  end

  assign sum   = {1'b0, x} + {1'b0, y} + {32'd0, add_cin};
  assign res   = is_arith ? sum[31:0] : logic_res;
  assign c_new = is_arith ? sum[32] : op_i.shift_carry;
  assign v_new = is_arith ? (~(x[31] ^ y[31]) & (x[31] ^ sum[31])) : op_i.flags_in[0];

  always_comb begin
    out_d.result      = res;
    out_d.write_dest  = op_i.write_dest;
    out_d.dest_out    = op_i.dest;
    out_d.flags_write = op_i.flags_write;
    out_d.nzcv_out    = op_i.flags_write ? {res[31], (res == 32'd0), c_new, v_new}
                                         : op_i.flags_in;
  end

  assign op_pop_o    = op_valid_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= op_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      out_q <= out_d;
    end
  end

  a_writes_something: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (out_q.write_dest || out_q.flags_write))
    else $error("result neither writes register nor flags");

  a_load_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |=> valid_q)
    else $error("popped operation not presented");

endmodule

/* src/barrel_shifter_alu_flags.sv */
// ----------------------------------------------------------------------------
// barrel_shifter_alu_flags - data-processing unit with barrel shifter
// Shifted or rotated second operand, 16-op ALU, NZCV flags, writeback select.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------
//   in       | input     | in_valid_i / in_stall_o   | bsaf_pkg::in_t
//   out      | output    | out_valid_o / out_stall_i | bsaf_pkg::out_t
//   cfg      | input     | cfg_valid_i / cfg_ready_o | core_variant (1 bit)
//
// One transfer in and one out per cycle while out_stall_i is low; shift and
// classify go into the queue, then the ALU result into the output register.
// The queue holds QueueDepth operations; in_stall_o rises only when it is full.
// Reset clears the queue, output valid and core_variant; no clearing pass.
// cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module barrel_shifter_alu_flags #(
  parameter int QueueDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bsaf_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bsaf_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);

  logic          core_variant_q;
  bsaf_pkg::op_t front_op;
  bsaf_pkg::op_t queue_op;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_variant_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      core_variant_q <= cfg_data_i;
    end
  end

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  bsaf_front u_front (
    .item_i         (in_data_i),
    .core_variant_i (core_variant_q),
    .op_o           (front_op)
  );

  bsaf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_op),
    .pop_i   (pop),
    .data_o  (queue_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bsaf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!q_empty),
    .op_i        (queue_op),
    .op_pop_o    (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
